>>> hdl/grp_pkg.sv
package grp_pkg;

  localparam int MaxNodes   = 32;
  localparam int MaxBorders = 64;
  localparam int EdgeSlots  = 2 * MaxBorders;
  localparam int NodeW      = $clog2(MaxNodes);
  localparam int CntW       = $clog2(MaxNodes + 1);
  localparam int EdgeW      = $clog2(EdgeSlots);
  localparam int ECntW      = $clog2(EdgeSlots + 1);
  localparam int IdW        = 16;

  typedef enum logic [1:0] {
    CMD_ADD_NODE = 2'd0,
    CMD_ADD_BORDER = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PATH = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_ACK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_SELF = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOOKUP,       // scan node table from newest down
    S_LOOKUP_WAIT,
    S_DECIDE,
    S_LINK_A,
    S_LINK_B,
    S_DFS_RD,       // read top of stack, stop when empty
    S_DFS_EDGE,     // edge memory read issued
    S_DFS_STEP,     // decide on edge target
    S_DFS_PUSH,     // push unvisited neighbor
    S_EMIT_TGT,
    S_EMIT_RD,
    S_EMIT_ID,
    S_EMIT_NODE,
    S_VERDICT,
    S_ACK,
    S_CLEAR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic             latch_in;
    logic             scan_start;
    logic             add_node;
    logic             link_a;
    logic             link_b;
    logic             dfs_start;
    logic             step_pop;
    logic             step_adv;
    logic             step_push;
    logic             emit_pop;
    logic             rd_id;
    logic             clear_all;
    logic             clear_visit;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic found_a;
    logic found_b;
    logic same;
    logic node_full;
    logic edge_full;
    logic edge_valid;
    logic tgt_hit;
    logic tgt_skip;
    logic stack_empty;
  } stat_t;

endpackage

>>> hdl/grp_ram.sv
module grp_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/grp_datapath.sv
module grp_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [grp_pkg::IdW-1:0]    first_id_i,
  input  logic [grp_pkg::IdW-1:0]    second_id_i,
  input  grp_pkg::ctrl_t             ctrl_i,
  output grp_pkg::stat_t             stat_o,
  output logic [grp_pkg::IdW-1:0]    id_o
);
  import grp_pkg::*;

  logic [IdW-1:0]   a_q, b_q;
  logic [CntW-1:0]  node_count_q;
  logic [ECntW-1:0] edge_count_q;
  logic [CntW-1:0]  scan_q;        // entries still to look at
  logic [NodeW-1:0] na_q, nb_q;
  logic             fa_q, fb_q;
  logic             scan_busy_q;
  logic [NodeW-1:0] scan_idx_q;    // index whose read data arrives now
  logic             scan_vld_q;
  logic [MaxNodes-1:0] hvalid_q;   // adjacency head not null
  logic [EdgeW-1:0] head_q [MaxNodes];
  logic [MaxNodes-1:0] visit_q;
  logic [CntW-1:0]  depth_q;
  logic [NodeW-1:0] top_node;
  logic             top_vld;
  logic [EdgeW-1:0] top_edge;

  // node id memory
  logic             id_we;
  logic [NodeW-1:0] id_waddr, id_raddr;
  logic [IdW-1:0]   id_rdata;
  // edge memories
  logic             e_we;
  logic [EdgeW-1:0] e_waddr;
  logic [NodeW-1:0] e_wtgt;
  logic             e_wnv;
  logic [EdgeW-1:0] e_wnext;
  logic [NodeW-1:0] e_rtgt;
  logic             e_rnv;
  logic [EdgeW-1:0] e_rnext;
  // stack memory: node, edge valid, edge
  logic             s_we;
  logic [NodeW-1:0] s_waddr, s_raddr;
  logic [NodeW+EdgeW:0] s_wdata, s_rdata;

  grp_ram #(.Width(IdW), .Depth(MaxNodes)) u_ids (
    .clk_i, .we_i(id_we), .waddr_i(id_waddr), .wdata_i(a_q),
    .raddr_i(id_raddr), .rdata_o(id_rdata));

  grp_ram #(.Width(NodeW + EdgeW + 1), .Depth(EdgeSlots)) u_edges (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i({e_wtgt, e_wnv, e_wnext}),
    .raddr_i(top_edge), .rdata_o({e_rtgt, e_rnv, e_rnext}));

  grp_ram #(.Width(NodeW + EdgeW + 1), .Depth(MaxNodes)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata));

  assign id_we    = ctrl_i.add_node && (node_count_q < CntW'(MaxNodes));
  assign id_waddr = node_count_q[NodeW-1:0];
  assign id_o     = id_rdata;

  // id read address: node to report, scan index, else the target
  logic [NodeW-1:0] scan_next;
  assign scan_next = NodeW'(scan_q - CntW'(1));
  always_comb begin
    if (ctrl_i.rd_id) id_raddr = s_rdata[NodeW+EdgeW:EdgeW+1];
    else if (scan_busy_q) id_raddr = scan_next;
    else id_raddr = nb_q;
  end

  // edge writes
  always_comb begin
    e_we = ctrl_i.link_a || ctrl_i.link_b;
    e_waddr = edge_count_q[EdgeW-1:0];
    e_wtgt  = ctrl_i.link_a ? nb_q : na_q;
    e_wnv   = ctrl_i.link_a ? hvalid_q[na_q] : hvalid_q[nb_q];
    e_wnext = ctrl_i.link_a ? head_q[na_q] : head_q[nb_q];
  end

  // top of stack decode (read data valid cycle after the address)
  assign top_node = s_rdata[NodeW+EdgeW:EdgeW+1];
  assign top_vld  = s_rdata[EdgeW];
  assign top_edge = s_rdata[EdgeW-1:0];

  // stack
  logic [NodeW-1:0] top_idx;
  assign top_idx = NodeW'(depth_q - CntW'(1));
  always_comb begin
    s_we = 1'b0;
    s_waddr = top_idx;
    s_wdata = {top_node, e_rnv, e_rnext};
    if (ctrl_i.dfs_start) begin
      s_we = 1'b1; s_waddr = '0;
      s_wdata = {na_q, hvalid_q[na_q], head_q[na_q]};
    end else if (ctrl_i.step_adv) begin
      s_we = 1'b1;
    end else if (ctrl_i.step_push) begin
      s_we = 1'b1; s_waddr = depth_q[NodeW-1:0];
      s_wdata = {e_rtgt, hvalid_q[e_rtgt], head_q[e_rtgt]};
    end
    // while reporting, keep reading the entry just popped
    s_raddr = ctrl_i.rd_id ? depth_q[NodeW-1:0] : top_idx;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      a_q <= first_id_i;
      b_q <= second_id_i;
    end
    if (ctrl_i.link_a) head_q[na_q] <= edge_count_q[EdgeW-1:0];
    if (ctrl_i.link_b) head_q[nb_q] <= edge_count_q[EdgeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
      edge_count_q <= '0;
      hvalid_q     <= '0;
      visit_q      <= '0;
      depth_q      <= '0;
      scan_q       <= '0;
      scan_busy_q  <= 1'b0;
      scan_vld_q   <= 1'b0;
      scan_idx_q   <= '0;
      fa_q <= 1'b0; fb_q <= 1'b0;
      na_q <= '0;   nb_q <= '0;
    end else begin
      if (ctrl_i.clear_all) begin
        node_count_q <= '0;
        edge_count_q <= '0;
        hvalid_q     <= '0;
        visit_q      <= '0;
        depth_q      <= '0;
      end
      if (id_we) begin
        node_count_q <= node_count_q + CntW'(1);
        hvalid_q[node_count_q[NodeW-1:0]] <= 1'b0;
      end
      if (ctrl_i.link_a) hvalid_q[na_q] <= 1'b1;
      if (ctrl_i.link_b) hvalid_q[nb_q] <= 1'b1;
      if (e_we) edge_count_q <= edge_count_q + ECntW'(1);
      // newest-first lookup, one entry per cycle
      if (ctrl_i.scan_start) begin
        scan_q <= node_count_q;
        scan_busy_q <= node_count_q != '0;
        scan_vld_q <= 1'b0;
        fa_q <= 1'b0; fb_q <= 1'b0;
      end else begin
        scan_vld_q <= scan_busy_q;
        scan_idx_q <= scan_next;
        if (scan_busy_q) begin
          scan_q <= scan_q - CntW'(1);
          if (scan_q == CntW'(1)) scan_busy_q <= 1'b0;
        end
        if (scan_vld_q) begin
          if (!fa_q && id_rdata == a_q) begin fa_q <= 1'b1; na_q <= scan_idx_q; end
          if (!fb_q && id_rdata == b_q) begin fb_q <= 1'b1; nb_q <= scan_idx_q; end
        end
      end
      // search
      if (ctrl_i.dfs_start) begin
        visit_q[na_q] <= 1'b1;
        depth_q <= CntW'(1);
      end
      if (ctrl_i.step_pop) depth_q <= depth_q - CntW'(1);
      if (ctrl_i.step_push) begin
        visit_q[e_rtgt] <= 1'b1;
        depth_q <= depth_q + CntW'(1);
      end
      if (ctrl_i.emit_pop) depth_q <= depth_q - CntW'(1);
      if (ctrl_i.clear_visit) begin
        visit_q <= '0;
        depth_q <= '0;
      end
    end
  end

  always_comb begin
    stat_o.scan_done   = !scan_busy_q && !scan_vld_q;
    stat_o.found_a     = fa_q;
    stat_o.found_b     = fb_q;
    stat_o.same        = na_q == nb_q;
    stat_o.node_full   = node_count_q >= CntW'(MaxNodes);
    stat_o.edge_full   = (edge_count_q + ECntW'(2)) > ECntW'(EdgeSlots);
    stat_o.edge_valid  = top_vld && ({1'b0, top_edge} < edge_count_q);
    stat_o.tgt_hit     = e_rtgt == nb_q;
    stat_o.tgt_skip    = visit_q[e_rtgt] || (depth_q >= CntW'(MaxNodes));
    stat_o.stack_empty = depth_q == '0;
  end
endmodule

>>> hdl/grp_ctrl.sv
module grp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [1:0]         cmd_i,
  input  grp_pkg::stat_t     stat_i,
  input  logic               out_free_i,
  output grp_pkg::ctrl_t     ctrl_o,
  output logic               busy_o,
  output logic               res_valid_o,
  output grp_pkg::kind_e     res_kind_o,
  output logic               res_reach_o,
  output grp_pkg::status_e   res_status_o,
  output logic               res_last_o
);
  import grp_pkg::*;

  state_e state_q, state_d;
  cmd_e   cmd_q;
  status_e st_q, st_d;
  logic   found_q, found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_ADD_NODE;
      st_q    <= ST_OK;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      found_q <= found_d;
      if (in_fire_i) cmd_q <= cmd_e'(cmd_i);
    end
  end

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    found_d = found_q;
    case (state_q)
      S_IDLE: if (in_fire_i) begin
        st_d = ST_OK;
        found_d = 1'b0;
        case (cmd_e'(cmd_i))
          CMD_ADD_NODE:  state_d = S_ACK;
          CMD_CLEAR:     state_d = S_CLEAR;
          default:       state_d = S_LOOKUP;
        endcase
      end
      S_LOOKUP: state_d = S_LOOKUP_WAIT;
      S_LOOKUP_WAIT: if (stat_i.scan_done) state_d = S_DECIDE;
      S_DECIDE: begin
        if (!stat_i.found_a || !stat_i.found_b) begin
          st_d = ST_UNKNOWN;
          state_d = (cmd_q == CMD_QUERY) ? S_VERDICT : S_ACK;
        end else if (cmd_q == CMD_QUERY) begin
          if (stat_i.same) begin
            found_d = 1'b1;
            state_d = S_EMIT_TGT;
          end else state_d = S_DFS_RD;
        end else if (stat_i.same) begin
          st_d = ST_SELF; state_d = S_ACK;
        end else if (stat_i.edge_full) begin
          st_d = ST_FULL; state_d = S_ACK;
        end else state_d = S_LINK_A;
      end
      S_LINK_A: state_d = S_LINK_B;
      S_LINK_B: state_d = S_ACK;
      S_DFS_RD: state_d = stat_i.stack_empty ? S_VERDICT : S_DFS_EDGE;
      S_DFS_EDGE: state_d = stat_i.edge_valid ? S_DFS_STEP : S_DFS_RD;
      S_DFS_STEP: begin
        if (stat_i.tgt_hit) begin
          found_d = 1'b1;
          state_d = S_EMIT_TGT;
        end else if (stat_i.tgt_skip) state_d = S_DFS_RD;
        else state_d = S_DFS_PUSH;
      end
      S_DFS_PUSH: state_d = S_DFS_RD;
      S_EMIT_TGT: if (out_free_i) state_d = stat_i.stack_empty ? S_VERDICT : S_EMIT_RD;
      S_EMIT_RD: state_d = S_EMIT_ID;
      S_EMIT_ID: state_d = S_EMIT_NODE;
      S_EMIT_NODE: if (out_free_i) state_d = stat_i.stack_empty ? S_VERDICT : S_EMIT_RD;
      S_VERDICT: if (out_free_i) state_d = S_IDLE;
      S_ACK: if (out_free_i) state_d = S_IDLE;
      S_CLEAR: state_d = S_ACK;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = state_q != S_IDLE;
    res_valid_o = 1'b0;
    res_kind_o = KIND_ACK;
    res_reach_o = 1'b0;
    res_status_o = st_q;
    res_last_o = 1'b0;
    case (state_q)
      S_IDLE: ctrl_o.latch_in = in_fire_i;
      S_LOOKUP: ctrl_o.scan_start = 1'b1;
      S_LINK_A: ctrl_o.link_a = 1'b1;
      S_LINK_B: ctrl_o.link_b = 1'b1;
      S_DECIDE: ctrl_o.dfs_start = (cmd_q == CMD_QUERY) && stat_i.found_a &&
                                   stat_i.found_b && !stat_i.same;
      S_DFS_EDGE: ctrl_o.step_pop = !stat_i.edge_valid;
      S_DFS_STEP: ctrl_o.step_adv = 1'b1;
      S_DFS_PUSH: ctrl_o.step_push = 1'b1;
      S_EMIT_TGT: begin
        res_valid_o = 1'b1;
        res_kind_o = KIND_PATH;
        res_status_o = ST_OK;
      end
      S_EMIT_RD: ctrl_o.emit_pop = 1'b1;
      S_EMIT_ID: ctrl_o.rd_id = 1'b1;
      S_EMIT_NODE: begin
        ctrl_o.rd_id = 1'b1;
        res_valid_o = 1'b1;
        res_kind_o = KIND_PATH;
        res_status_o = ST_OK;
      end
      S_VERDICT: begin
        res_valid_o = 1'b1;
        res_kind_o = KIND_VERDICT;
        res_reach_o = found_q;
        res_last_o = 1'b1;
        ctrl_o.clear_visit = out_free_i;
      end
      S_ACK: begin
        res_valid_o = 1'b1;
        res_last_o = 1'b1;
        ctrl_o.add_node = out_free_i && (cmd_q == CMD_ADD_NODE) && (st_q == ST_OK);
      end
      S_CLEAR: ctrl_o.clear_all = 1'b1;
      default: ;
    endcase
    if (state_q == S_ACK && cmd_q == CMD_ADD_NODE && stat_i.node_full)
      res_status_o = ST_FULL;
  end
endmodule

>>> hdl/graph_reachability_path_top.sv
// Command flow: add node goes straight to its acknowledge; clear resets the tables first;
// add border and an unknown-node query scan the node table before their result.
// Query search after the lookup pops, reads edge entries and pushes unvisited neighbours;
// then the target, each further path node and the verdict are emitted.
// Throughput: one command at a time, next accepted the cycle after the final result
// is loaded. Reset (rst_ni low, asynchronous): empty graph, no borders, idle.
module graph_reachability_path_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // first_id[15:0], second_id[31:16]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // node_id[15:0], reachable[16], status[18:17]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);
  import grp_pkg::*;

  ctrl_t   ctrl;
  stat_t   stat;
  logic    busy, res_valid, res_reach, res_last, in_fire;
  kind_e   res_kind;
  status_e res_status;
  logic [IdW-1:0] dp_id;

  // output register
  logic        ov_q;
  logic [23:0] od_q;
  kind_e       okind_q;
  logic        ol_q;
  logic        out_free;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;

  grp_datapath u_dp (
    .clk_i, .rst_ni,
    .first_id_i(s_axis_tdata[15:0]), .second_id_i(s_axis_tdata[31:16]),
    .ctrl_i(ctrl), .stat_o(stat), .id_o(dp_id));

  grp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .cmd_i(s_axis_tuser),
    .stat_i(stat), .out_free_i(out_free), .ctrl_o(ctrl), .busy_o(busy),
    .res_valid_o(res_valid), .res_kind_o(res_kind), .res_reach_o(res_reach),
    .res_status_o(res_status), .res_last_o(res_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (out_free) ov_q <= res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      od_q <= {5'b00000, res_status, res_reach,
               (res_kind == KIND_PATH) ? dp_id : 16'h0000};
      okind_q <= res_kind;
      ol_q <= res_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = ol_q;
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import grp_pkg::*;

  // Cycles with no transaction before the run is abandoned
  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // first_id, second_id
  logic [1:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // node_id, reachable, status
  logic [1:0]  m_axis_tuser;        // kind
  logic        m_axis_tlast;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] node_id;
    logic        reachable;
    status_e     status;
    logic        last;
  } result_t;

  always #1 clk_i = ~clk_i;

  graph_reachability_path_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // Shadow graph state
  logic [15:0] g_ids[MaxNodes];
  int          g_count;
  int          g_head[MaxNodes];
  int          g_etgt[EdgeSlots];
  int          g_enext[EdgeSlots];
  int          g_ecount;

  result_t     pending_results[$];
  int          errors;
  int          n_sent;
  int          n_checked;
  int          n_paths;
  int          n_found;
  int          quiet_cycles;
  bit          idle_enable;

  task automatic report_mismatch(input string what, input result_t got, input result_t exp_r);
    $display("MISMATCH %s: got k%0d id%h r%0d s%0d l%0d exp k%0d id%h r%0d s%0d l%0d",
             what, got.kind, got.node_id, got.reachable, got.status, got.last,
             exp_r.kind, exp_r.node_id, exp_r.reachable, exp_r.status, exp_r.last);
    errors++;
  endtask

  function automatic void push_result(kind_e k, logic [15:0] id, logic r, status_e s, logic l);
    result_t x;
    x.kind = k; x.node_id = id; x.reachable = r; x.status = s; x.last = l;
    pending_results.push_back(x);
  endfunction

  function automatic int find_node(logic [15:0] id);
    for (int i = g_count - 1; i >= 0; i--)
      if (g_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void wipe_graph();
    g_count = 0;
    g_ecount = 0;
    for (int i = 0; i < MaxNodes; i++) g_head[i] = 255;
  endfunction

  // Depth-first search along adjacency lists, newest border first
  function automatic void predict_search(int src, int tgt);
    bit seen[MaxNodes];
    int stk_n[MaxNodes];
    int stk_e[MaxNodes];
    int depth;
    int e;
    int m;
    bit hit;
    hit = 0;
    if (src == tgt) begin
      push_result(KIND_PATH, g_ids[tgt], 1'b0, ST_OK, 1'b0);
      push_result(KIND_VERDICT, '0, 1'b1, ST_OK, 1'b1);
      n_found++;
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    seen[src] = 1;
    stk_n[0] = src;
    stk_e[0] = g_head[src];
    depth = 1;
    while (depth > 0) begin
      e = stk_e[depth - 1];
      if (e >= g_ecount) begin
        depth--;
        continue;
      end
      stk_e[depth - 1] = g_enext[e];
      m = g_etgt[e];
      if (m == tgt) begin
        hit = 1;
        break;
      end
      if (seen[m] || depth >= MaxNodes) continue;
      seen[m] = 1;
      stk_n[depth] = m;
      stk_e[depth] = g_head[m];
      depth++;
    end
    if (hit) begin
      n_found++;
      push_result(KIND_PATH, g_ids[tgt], 1'b0, ST_OK, 1'b0);
      while (depth > 0) begin
        depth--;
        push_result(KIND_PATH, g_ids[stk_n[depth]], 1'b0, ST_OK, 1'b0);
      end
    end
    push_result(KIND_VERDICT, '0, hit, ST_OK, 1'b1);
  endfunction

  function automatic void predict_command(cmd_e cmd, logic [15:0] a, logic [15:0] b);
    int na;
    int nb;
    case (cmd)
      CMD_ADD_NODE: begin
        if (g_count >= MaxNodes) begin
          push_result(KIND_ACK, '0, 1'b0, ST_FULL, 1'b1);
        end else begin
          g_ids[g_count] = a;
          g_head[g_count] = 255;
          g_count++;
          push_result(KIND_ACK, '0, 1'b0, ST_OK, 1'b1);
        end
      end
      CMD_ADD_BORDER: begin
        na = find_node(a);
        nb = find_node(b);
        if (na < 0 || nb < 0) push_result(KIND_ACK, '0, 1'b0, ST_UNKNOWN, 1'b1);
        else if (na == nb) push_result(KIND_ACK, '0, 1'b0, ST_SELF, 1'b1);
        else if (g_ecount + 2 > EdgeSlots) push_result(KIND_ACK, '0, 1'b0, ST_FULL, 1'b1);
        else begin
          g_etgt[g_ecount] = nb; g_enext[g_ecount] = g_head[na]; g_head[na] = g_ecount;
          g_ecount++;
          g_etgt[g_ecount] = na; g_enext[g_ecount] = g_head[nb]; g_head[nb] = g_ecount;
          g_ecount++;
          push_result(KIND_ACK, '0, 1'b0, ST_OK, 1'b1);
        end
      end
      CMD_QUERY: begin
        n_paths++;
        na = find_node(a);
        nb = find_node(b);
        if (na < 0 || nb < 0) push_result(KIND_VERDICT, '0, 1'b0, ST_UNKNOWN, 1'b1);
        else predict_search(na, nb);
      end
      default: begin
        wipe_graph();
        push_result(KIND_ACK, '0, 1'b0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // Send one command; prediction happens at acceptance.
  // tvalid stays high after a transaction until the next command or an idle gap.
  task automatic send_command(cmd_e cmd, logic [15:0] a, logic [15:0] b);
    if (idle_enable && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (idle_enable && $urandom_range(99) < 30) @(posedge clk_i);
    end
    s_axis_tdata <= {b, a};
    s_axis_tuser <= cmd;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_command(cmd, a, b);
    n_sent++;
  endtask

  // Result side: random stall, compare with oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = kind_e'(m_axis_tuser);
        got.node_id   = m_axis_tdata[15:0];
        got.reachable = m_axis_tdata[16];
        got.status    = status_e'(m_axis_tdata[18:17]);
        got.last      = m_axis_tlast;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected", got, '0);
        end else begin
          if (got !== pending_results[0]) report_mismatch("field", got, pending_results[0]);
          void'(pending_results.pop_front());
          n_checked++;
        end
      end
      m_axis_tready <= !(idle_enable && $urandom_range(99) < 30);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_id();
    if (g_count > 0 && $urandom_range(9) < 8) return g_ids[$urandom_range(g_count - 1)];
    return 16'($urandom());
  endfunction

  task automatic test_directed();
    send_command(CMD_QUERY, 16'h0000, 16'hffff);       // empty map
    send_command(CMD_ADD_BORDER, 16'h0001, 16'h0002);  // unknown ends
    send_command(CMD_ADD_NODE, 16'h0000, 16'hffff);
    send_command(CMD_ADD_NODE, 16'hffff, 16'h0000);
    send_command(CMD_ADD_NODE, 16'h1234, 16'h0000);
    send_command(CMD_ADD_NODE, 16'hffff, 16'h0000);    // duplicate id, newest wins
    send_command(CMD_ADD_BORDER, 16'h0000, 16'h0000);  // self border
    send_command(CMD_ADD_BORDER, 16'h0000, 16'h0777);  // one end unknown
    send_command(CMD_ADD_BORDER, 16'h0000, 16'h1234);
    send_command(CMD_ADD_BORDER, 16'h1234, 16'hffff);
    send_command(CMD_QUERY, 16'h0000, 16'hffff);       // path through 1234
    send_command(CMD_QUERY, 16'hffff, 16'hffff);       // self query
    send_command(CMD_QUERY, 16'h0000, 16'h0777);
    send_command(CMD_ADD_NODE, 16'h5555, 16'h0000);
    send_command(CMD_QUERY, 16'h0000, 16'h5555);       // unreachable
    send_command(CMD_CLEAR, 16'hffff, 16'hffff);
    send_command(CMD_QUERY, 16'h0000, 16'h1234);
  endtask

  // Fill tables to capacity: node full and border full
  task automatic test_full_tables();
    send_command(CMD_CLEAR, 16'h0, 16'h0);
    for (int i = 0; i <= MaxNodes; i++) send_command(CMD_ADD_NODE, 16'(i * 3), 16'h0);
    for (int i = 0; i < MaxBorders + 1; i++)
      send_command(CMD_ADD_BORDER, 16'((i % MaxNodes) * 3),
                   16'(((i + 1 + i / MaxNodes) % MaxNodes) * 3));
    send_command(CMD_QUERY, 16'h0, 16'(93));
    send_command(CMD_QUERY, 16'(45), 16'(3));
  endtask

  // Random commands on the dense graph: queries, node and border adds (rejected while full), occasional clear
  task automatic test_random();
    int roll;
    for (int n = 0; n < 12; n++) begin
      roll = $urandom_range(99);
      if (roll < 3) send_command(CMD_CLEAR, 16'($urandom()), 16'($urandom()));
      else if (roll < 30 || g_count < 3)
        send_command(CMD_ADD_NODE, ($urandom_range(3) == 0) ? 16'($urandom()) :
                     16'($urandom_range(40)), 16'($urandom()));
      else if (roll < 60) send_command(CMD_ADD_BORDER, pick_id(), pick_id());
      else send_command(CMD_QUERY, pick_id(), pick_id());
    end
  endtask

  initial begin
    errors = 0; n_sent = 0; n_checked = 0; n_paths = 0; n_found = 0;
    quiet_cycles = 0;
    idle_enable = 1'b0;
    wipe_graph();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    idle_enable = 1'b1;
    test_full_tables();
    test_random();
    wait_drained();
    $display("run: %0d commands, %0d results checked", n_sent, n_checked);
    $display("run: %0d queries, %0d with a path found, %0d errors", n_paths, n_found, errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
